@@ rtl/core/frws_pkg.sv @@
`timescale 1ns / 1ps
package frws_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int PERIOD_W = 16;
  localparam int TOTAL_W = $clog2(RING_DEPTH * 65535 + 1);
  localparam int N_W = $clog2(RING_DEPTH + 1);
  localparam int RATE_W = 17;
  localparam int RATE_SCALE = 100000;
  localparam int DIVD_W = $clog2(RATE_SCALE * RING_DEPTH + 1);

  localparam int REG_W = 7;
  localparam logic [REG_W-1:0] RECENT_RESET = 7'd10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [0:0] {
    REG_RECENT_FRAMES = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  dividend;
    logic [TOTAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [RATE_W-1:0] fps_high;
    logic [RATE_W-1:0] fps_mean;
    logic [RATE_W-1:0] fps_low;
    logic [RATE_W-1:0] fps_now;
  } frws_result_t;

endpackage

@@ rtl/core/frws_ram.sv @@
`timescale 1ns / 1ps
module frws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/frws_div.sv @@
`timescale 1ns / 1ps
module frws_div (
  input  logic               clk,
  input  logic               rst_n,
  input  frws_pkg::div_req_t req,
  output frws_pkg::div_rsp_t rsp
);
  import frws_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIVD_W-1:0]  quo_r;
  logic [TOTAL_W-1:0] rem_r;
  logic [TOTAL_W-1:0] dsr_r;

  logic [TOTAL_W:0]   part;
  logic [TOTAL_W+1:0] diff;
  logic               ge;

  // one restoring step: bring down the next dividend bit, try the subtract
  assign part = {rem_r, quo_r[DIVD_W-1]};
  assign diff = {1'b0, part} - {2'b00, dsr_r};
  assign ge   = ~diff[TOTAL_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= '0;
      rem_r  <= '0;
      dsr_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        rem_r <= ge ? diff[TOTAL_W-1:0] : part[TOTAL_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[RATE_W-1:0];

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

@@ rtl/core/frws_core.sv @@
`timescale 1ns / 1ps
module frws_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [frws_pkg::PERIOD_W-1:0] frame_ms,
  input  logic [frws_pkg::REG_W-1:0]    recent_frames,
  input  logic                          out_free,
  output logic                          res_load,
  output frws_pkg::frws_result_t        res
);
  import frws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD_RD,
    ST_OLD_UPD,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_NOW,
    SEL_LOW,
    SEL_MEAN,
    SEL_HIGH
  } div_sel_t;

  state_t              state_r;
  div_sel_t            sel_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [PTR_W-1:0]    wa_r;
  logic [PTR_W-1:0]    idx_r;
  logic [PTR_W-1:0]    idx_d_r;
  logic                walk_d_r;
  logic                ent_vld_d_r;
  logic [RING_DEPTH-1:0] valid_r;
  logic [PERIOD_W-1:0] period_r;
  logic [N_W-1:0]      n_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  sum_r;
  logic [PERIOD_W-1:0] max_r;
  logic [PERIOD_W-1:0] min_r;
  frws_result_t        res_r;

  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic                wr_en;
  logic [PERIOD_W-1:0] rd_data;
  logic [PERIOD_W-1:0] ent;
  logic [N_W-1:0]      n_eff;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign rd_en   = (state_r == ST_OLD_RD) || (state_r == ST_WALK);
  assign rd_addr = (state_r == ST_WALK) ? wa_r : ptr_r;
  assign wr_en   = (state_r == ST_OLD_UPD);

  frws_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr_r),
    .wr_data (period_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // an entry never written since reset holds a period of one
  assign ent = ent_vld_d_r ? rd_data : PERIOD_W'(1);

  always_comb begin
    if (recent_frames == '0) begin
      n_eff = N_W'(1);
    end else if (int'(recent_frames) > RING_DEPTH) begin
      n_eff = N_W'(RING_DEPTH);
    end else begin
      n_eff = N_W'(recent_frames);
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_DIV_GO);
    unique case (sel_r)
      SEL_NOW: begin
        div_req.dividend = DIVD_W'(n_r * RATE_SCALE);
        div_req.divisor  = sum_r;
      end
      SEL_LOW: begin
        div_req.dividend = DIVD_W'(RATE_SCALE);
        div_req.divisor  = TOTAL_W'(max_r);
      end
      SEL_MEAN: begin
        div_req.dividend = DIVD_W'(RATE_SCALE * RING_DEPTH);
        div_req.divisor  = total_r;
      end
      SEL_HIGH: begin
        div_req.dividend = DIVD_W'(RATE_SCALE);
        div_req.divisor  = TOTAL_W'(min_r);
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  frws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_NOW;
      ptr_r       <= '0;
      wa_r        <= '0;
      idx_r       <= '0;
      idx_d_r     <= '0;
      walk_d_r    <= 1'b0;
      ent_vld_d_r <= 1'b0;
      valid_r     <= '0;
      period_r    <= '0;
      n_r         <= '0;
      total_r     <= TOTAL_W'(RING_DEPTH);
      sum_r       <= '0;
      max_r       <= '0;
      min_r       <= '1;
      res_r       <= '0;
    end else begin
      if (rd_en) begin
        ent_vld_d_r <= valid_r[rd_addr];
      end
      walk_d_r <= (state_r == ST_WALK);
      idx_d_r  <= idx_r;

      // fold the entry that the walk read in the previous cycle
      if (walk_d_r) begin
        if (N_W'(idx_d_r) < n_r) begin
          sum_r <= sum_r + TOTAL_W'(ent);
        end
        if (ent > max_r) begin
          max_r <= ent;
        end
        if (ent < min_r) begin
          min_r <= ent;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ptr_r    <= (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
            period_r <= (frame_ms == '0) ? PERIOD_W'(1) : frame_ms;
            n_r      <= n_eff;
            state_r  <= ST_OLD_RD;
          end
        end
        ST_OLD_RD: begin
          state_r <= ST_OLD_UPD;
        end
        ST_OLD_UPD: begin
          // replace the evicted entry in the running total
          total_r        <= total_r - TOTAL_W'(ent) + TOTAL_W'(period_r);
          valid_r[ptr_r] <= 1'b1;
          wa_r           <= ptr_r;
          idx_r          <= '0;
          sum_r          <= '0;
          max_r          <= '0;
          min_r          <= '1;
          state_r        <= ST_WALK;
        end
        ST_WALK: begin
          // walk newest to oldest so the first n reads form the window
          wa_r  <= (wa_r == '0) ? PTR_W'(RING_DEPTH - 1) : wa_r - 1'b1;
          idx_r <= idx_r + 1'b1;
          if (idx_r == PTR_W'(RING_DEPTH - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          sel_r   <= SEL_NOW;
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (sel_r)
              SEL_NOW: begin
                res_r.fps_now <= div_rsp.quotient;
                sel_r         <= SEL_LOW;
                state_r       <= ST_DIV_GO;
              end
              SEL_LOW: begin
                res_r.fps_low <= div_rsp.quotient;
                sel_r         <= SEL_MEAN;
                state_r       <= ST_DIV_GO;
              end
              SEL_MEAN: begin
                res_r.fps_mean <= div_rsp.quotient;
                sel_r          <= SEL_HIGH;
                state_r        <= ST_DIV_GO;
              end
              SEL_HIGH: begin
                res_r.fps_high <= div_rsp.quotient;
                state_r        <= ST_OUT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign res_load = (state_r == ST_OUT) && out_free;
  assign res      = res_r;

  a_extremes_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO) |-> (min_r != '0) && (max_r >= min_r))
    else $error("walk left bad min/max");

  a_total_floor: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= TOTAL_W'(RING_DEPTH))
    else $error("ring total below ring depth");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside wait state");

endmodule

@@ rtl/core/frame_rate_window_stats_top.sv @@
`timescale 1ns / 1ps
// Path from an input transaction to out_tvalid: ring update (read of the evicted entry, then write),
//   a walk of the period memory over all 64 entries, a drain state, 4 divisions in turn,
//   then the output register.
// Flow: one item at a time, limited by the single memory read port and the shared
//   bit-serial divider; the next item is taken while a result waits in the output register.
// Reset: synchronous active-low rst_n; every ring entry reads as 1, pointer 0, recent_frames 10.
module frame_rate_window_stats_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // frame_ms [15:0]
  input  logic [frws_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // fps_now [16:0], fps_low [33:17], fps_mean [50:34], fps_high [67:51], zero [71:68]
  output logic [frws_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [frws_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [frws_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [frws_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import frws_pkg::*;

  logic [REG_W-1:0] recent_r;
  logic             out_valid_r;
  frws_result_t     out_data_r;

  reg_idx_t         reg_idx;
  logic             cfg_wr;
  logic             core_ready;
  logic             out_free;
  logic             res_load;
  frws_result_t     res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (reg_idx)
      REG_RECENT_FRAMES: cfg_prdata = CFG_DATA_W'(recent_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= RECENT_RESET;
    end else if (cfg_wr && (reg_idx == REG_RECENT_FRAMES)) begin
      recent_r <= cfg_pwdata[REG_W-1:0];
    end
  end

  frws_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (core_ready),
    .frame_ms      (in_tdata[PERIOD_W-1:0]),
    .recent_frames (recent_r),
    .out_free      (out_free),
    .res_load      (res_load),
    .res           (res)
  );

  assign in_tready = core_ready;
  assign out_free  = !out_valid_r || out_tready;

  // output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 4 * RATE_W){1'b0}}, out_data_r};

endmodule

@@ tb/sv/tb_frame_rate_window_stats_top.sv @@
`timescale 1ns / 1ps
module tb_frame_rate_window_stats_top;
  import frws_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 400;
  localparam int PHASE_FRAMES = 560;
  localparam logic [CFG_ADDR_W-1:0] ADDR_RECENT = CFG_ADDR_W'(4 * REG_RECENT_FRAMES);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = ADDR_RECENT + CFG_ADDR_W'(4);

  // Mirror of the ring statistics; predicts the four rates for each accepted frame.
  class frame_stats_checker;
    bit [PERIOD_W-1:0] period_ring [RING_DEPTH];
    bit [PTR_W-1:0]    wr_ptr;
    bit [TOTAL_W-1:0]  ring_sum;
    bit [REG_W-1:0]    window_reg;
    frws_result_t      expected_rates [$];
    int                errors;
    int                frames;
    int                checked;

    function new();
      foreach (period_ring[i]) period_ring[i] = 1;
      wr_ptr = '0;
      ring_sum = TOTAL_W'(RING_DEPTH);
      window_reg = RECENT_RESET;
      errors = 0;
      frames = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == ADDR_RECENT) window_reg = data[REG_W-1:0];
    endfunction

    function bit [RATE_W-1:0] rate(bit [DIVD_W-1:0] dividend, bit [TOTAL_W-1:0] divisor);
      bit [DIVD_W-1:0] q;
      q = dividend / divisor;
      return q[RATE_W-1:0];
    endfunction

    function void note_frame(logic [PERIOD_W-1:0] ms);
      bit [PERIOD_W-1:0] p;
      bit [N_W-1:0]      n;
      bit [PTR_W-1:0]    pos;
      bit [TOTAL_W-1:0]  recent;
      bit [PERIOD_W-1:0] big;
      bit [PERIOD_W-1:0] tiny;
      frws_result_t      r;
      p = (ms == '0) ? PERIOD_W'(1) : ms;
      // advance first, then overwrite the oldest entry
      wr_ptr = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      ring_sum = ring_sum - TOTAL_W'(period_ring[wr_ptr]) + TOTAL_W'(p);
      period_ring[wr_ptr] = p;
      if (window_reg == '0) n = N_W'(1);
      else if (window_reg > RING_DEPTH) n = N_W'(RING_DEPTH);
      else n = N_W'(window_reg);
      recent = '0;
      pos = wr_ptr;
      for (int i = 0; i < n; i++) begin
        recent += TOTAL_W'(period_ring[pos]);
        pos = (pos == '0) ? PTR_W'(RING_DEPTH - 1) : pos - PTR_W'(1);
      end
      big = '0;
      tiny = '1;
      foreach (period_ring[i]) begin
        if (period_ring[i] > big) big = period_ring[i];
        if (period_ring[i] < tiny) tiny = period_ring[i];
      end
      r.fps_now  = rate(DIVD_W'(RATE_SCALE * n), recent);
      r.fps_low  = rate(DIVD_W'(RATE_SCALE), TOTAL_W'(big));
      r.fps_mean = rate(DIVD_W'(RATE_SCALE * RING_DEPTH), ring_sum);
      r.fps_high = rate(DIVD_W'(RATE_SCALE), TOTAL_W'(tiny));
      expected_rates.push_back(r);
      frames++;
    endfunction

    function void check_rates(logic [OUT_TDATA_W-1:0] tdata);
      string field_names [4] = '{"fps_now", "fps_low", "fps_mean", "fps_high"};
      frws_result_t want;
      logic [$bits(frws_result_t)-1:0] want_bits;
      if (expected_rates.size() == 0) begin
        $error("unexpected result transaction: %h", tdata);
        errors++;
        return;
      end
      want = expected_rates.pop_front();
      want_bits = want;
      checked++;
      for (int k = 0; k < 4; k++) begin
        if (tdata[k*RATE_W +: RATE_W] !== want_bits[k*RATE_W +: RATE_W]) begin
          $error("%s: expected %0d, actual %0d", field_names[k],
                 want_bits[k*RATE_W +: RATE_W], tdata[k*RATE_W +: RATE_W]);
          errors++;
        end
      end
      if (tdata[OUT_TDATA_W-1:$bits(frws_result_t)] !== '0) begin
        $error("pad: expected 0, actual %0h", tdata[OUT_TDATA_W-1:$bits(frws_result_t)]);
        errors++;
      end
    endfunction

    function void report_leftover();
      if (expected_rates.size() != 0) begin
        $error("results never arrived: expected 0 pending, actual %0d", expected_rates.size());
        errors += expected_rates.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  frame_stats_checker sb = new();
  int send_idle = 38;
  int recv_idle = 63;
  int idle_cycles = 0;
  int window_settings = 0;

  frame_rate_window_stats_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_rates(out_tdata);
      if (in_tvalid && in_tready) sb.note_frame(in_tdata[PERIOD_W-1:0]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_frame(input logic [IN_TDATA_W-1:0] ms);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    // occasional long gap so the next frame lands on any stage of the pipeline
    if (send_idle != 0 && $urandom_range(99) < 4) gap += $urandom_range(1, 180);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ms;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_rates.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      sb.write_reg(addr, data);
    end else begin
      want = CFG_DATA_W'(sb.window_reg);
      if (cfg_prdata !== want) begin
        $error("recent_frames readback: expected %0d, actual %0d", want, cfg_prdata);
        sb.errors++;
      end
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Change a register only once the pipeline is empty, then read the window back.
  task automatic reconfigure(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_access(1'b1, addr, data);
    cfg_access(1'b0, ADDR_RECENT, '0);
    if (addr == ADDR_RECENT) window_settings++;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pick_frame(int style, int base);
    case (style)
      0: begin
        case ($urandom_range(9))
          0: return '0;
          1: return '1;
          2: return IN_TDATA_W'($urandom);
          3: return IN_TDATA_W'($urandom_range(1, 3));
          default: return IN_TDATA_W'($urandom_range(5, 60));
        endcase
      end
      1: return IN_TDATA_W'(base + $urandom_range(0, 8));
      default: return IN_TDATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_window();
    case ($urandom_range(6))
      0: return '0;
      1: return 32'd1;
      2: return 32'd64;
      3: return 32'd65;
      4: return 32'd127;
      5: return $urandom;
      default: return CFG_DATA_W'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int style;
    int base;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value of the window, then ring extremes under it
    cfg_access(1'b0, ADDR_RECENT, '0);
    send_frame(16'h0000);
    send_frame(16'hFFFF);
    send_frame(16'h0001);
    send_frame(16'hFFFF);
    send_frame(16'h0000);
    send_frame(16'h8000);
    send_frame(16'h7FFF);
    send_frame(16'h5555);
    send_frame(16'hAAAA);
    reconfigure(ADDR_RECENT, 32'd1);
    send_frame(16'hFFFF);
    send_frame(16'h0000);
    // a window of zero acts as one
    reconfigure(ADDR_RECENT, 32'd0);
    send_frame(16'd300);
    reconfigure(ADDR_RECENT, 32'd64);
    send_frame(16'hFFFF);
    send_frame(16'hFFFF);
    send_frame(16'd2);
    // windows past the ring clamp to the ring depth
    reconfigure(ADDR_RECENT, 32'd65);
    send_frame(16'd7);
    // upper bits of the write are dropped
    reconfigure(ADDR_RECENT, 32'hFFFF_FF80);
    send_frame(16'd9);
    // writes outside the register map leave the window alone
    reconfigure(ADDR_UNMAPPED, 32'd5);
    send_frame(16'd11);
    reconfigure(ADDR_RECENT, 32'd127);
    send_frame(16'hFFFF);

    style = 0;
    base = 1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 38; recv_idle = 63; end
        1: begin send_idle = 63; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        if (k % 48 == 0) begin
          style = $urandom_range(2);
          base = $urandom_range(1, 200);
        end
        if (k > 0 && k % 140 == 0) begin
          if ($urandom_range(7) == 0) reconfigure(ADDR_UNMAPPED, $urandom);
          else reconfigure(ADDR_RECENT, pick_window());
        end
        // hold off the sender until every result is back
        if (k == 300) drain_results();
        send_frame(pick_frame(style, base));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.report_leftover();
    $display("tb: %0d frames sent, %0d rate results checked, %0d window writes",
             sb.frames, sb.checked, window_settings);
    $display("tb: sender/receiver idle mixes 38/63, 63/38 and none, with clamped windows");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/frws_pkg.sv
rtl/core/frws_ram.sv
rtl/core/frws_div.sv
rtl/core/frws_core.sv
rtl/core/frame_rate_window_stats_top.sv
tb/sv/tb_frame_rate_window_stats_top.sv
